@@ sv/ray_triangle_hit_test_defines.svh @@
// Assertion helpers for the ray/triangle hit test.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef RAY_TRIANGLE_HIT_TEST_DEFINES_SVH
`define RAY_TRIANGLE_HIT_TEST_DEFINES_SVH

// Same-cycle implication
`define RTH_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication
`define RTH_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

@@ sv/rth_pkg.sv @@
`timescale 1ns / 1ps

package rth_pkg;

  // Field widths
  localparam int COORD_WIDTH      = 32;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int CFG_IDX_W        = 8;
  localparam int CFG_DATA_W       = COORD_WIDTH;

  // Datapath widths, all exact (no rounding anywhere before the divide)
  localparam int DIFF_W  = COORD_WIDTH + 1;        // vertex - start
  localparam int PROD_W  = 2 * DIFF_W;             // one cross-product term
  localparam int CROSS_W = PROD_W + 1;             // cross-product component
  localparam int LO_W    = DIFF_W + 1;             // low slice of a component
  localparam int HI_W    = CROSS_W - LO_W;         // high slice, signed
  localparam int HP_W    = DIFF_W + HI_W;          // pq * high slice
  localparam int LP_W    = DIFF_W + LO_W + 1;      // pq * low slice
  localparam int U_W     = DIFF_W + CROSS_W + 2;   // triple product
  localparam int SUM_W   = U_W + 1;                // u + v + w, unsigned
  localparam int REM_W   = SUM_W + WEIGHT_FRAC_BITS + 1;
  localparam int WGT_W   = WEIGHT_FRAC_BITS + 1;   // Q1.F weight
  localparam int DIV_STG = WGT_W;                  // one quotient bit per stage

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_START_Z = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_X  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_Y  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_Z  = CFG_IDX_W'(5);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic [WGT_W-1:0]              weight_t;

  // Per-beat control travelling alongside the datapath
  typedef struct packed {
    logic valid;
    logic hit;
    logic degenerate;
  } rth_flags_t;

endpackage

@@ sv/rth_if.sv @@
`timescale 1ns / 1ps

// Triangle channel
interface rth_tri_if import rth_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t a_x, a_y, a_z;
  coord_t b_x, b_y, b_z;
  coord_t c_x, c_y, c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

// Result channel
interface rth_res_if import rth_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    hit;
  logic    degenerate;
  weight_t weight_a, weight_b, weight_c;

  modport source (output valid, hit, degenerate, weight_a, weight_b, weight_c,
                  input ready);
  modport sink (input valid, hit, degenerate, weight_a, weight_b, weight_c,
                output ready);
endinterface

@@ sv/rth_cfg.sv @@
`timescale 1ns / 1ps

module rth_cfg import rth_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output coord_t                start_o [3],
  output diff_t                 pq_o [3]
);

  coord_t start_q [3];
  coord_t stop_q  [3];
  diff_t  pq_q    [3];

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        start_q[i] <= '0;
        stop_q[i]  <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_X: start_q[0] <= cfg_data_i[COORD_WIDTH-1:0];
        CFG_START_Y: start_q[1] <= cfg_data_i[COORD_WIDTH-1:0];
        CFG_START_Z: start_q[2] <= cfg_data_i[COORD_WIDTH-1:0];
        CFG_STOP_X:  stop_q[0]  <= cfg_data_i[COORD_WIDTH-1:0];
        CFG_STOP_Y:  stop_q[1]  <= cfg_data_i[COORD_WIDTH-1:0];
        CFG_STOP_Z:  stop_q[2]  <= cfg_data_i[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Ray direction (stop - start), registered behind the start and stop registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) pq_q[i] <= '0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        pq_q[i] <= {stop_q[i][COORD_WIDTH-1], stop_q[i]}
                 - {start_q[i][COORD_WIDTH-1], start_q[i]};
      end
    end
  end

  assign start_o = start_q;
  assign pq_o    = pq_q;

endmodule

@@ sv/rth_geom.sv @@
`timescale 1ns / 1ps

// Six-stage pipeline: differences, cross terms, cross components,
// split products with the ray direction, triple products, hit flags and sum.
module rth_geom import rth_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  coord_t           vert_i [3][3],
  input  coord_t           start_i [3],
  input  diff_t            pq_i [3],
  output rth_flags_t       flags_o,
  output logic [SUM_W-1:0] x_o [3],
  output logic [SUM_W-1:0] s_o
);

  // Vertex pairs for u (c,b), v (a,c), w (b,a)
  localparam int X_VTX [3] = '{2, 0, 1};
  localparam int Y_VTX [3] = '{1, 2, 0};
  // Axis rotation for the cross product
  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

  logic [4:0]                v_q;
  rth_flags_t                flags_q;
  diff_t                     d_q  [3][3];
  logic signed [PROD_W-1:0]  m_q  [3][3][2];
  logic signed [CROSS_W-1:0] cr_q [3][3];
  logic signed [HP_W-1:0]    hi_q [3][3];
  logic signed [LP_W-1:0]    lo_q [3][3];
  logic signed [U_W-1:0]     u_q  [3];
  logic signed [U_W-1:0]     u_d  [3];
  logic [SUM_W-1:0]          x_q  [3];
  logic [SUM_W-1:0]          s_q;
  logic [SUM_W-1:0]          s_d;
  logic                      neg_d;

  // Valid chain and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      flags_q <= '0;
    end else if (en_i) begin
      v_q                <= {v_q[3:0], valid_i};
      flags_q.valid      <= v_q[4];
      flags_q.hit        <= !neg_d && (s_d != '0);
      flags_q.degenerate <= !neg_d && (s_d == '0);
    end
  end

  // Triple product sums of the split partial products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u_d[k] = '0;
      for (int j = 0; j < 3; j++) begin
        u_d[k] = u_d[k] + (U_W'(hi_q[k][j]) <<< LO_W) + U_W'(lo_q[k][j]);
      end
    end
    neg_d = u_q[0][U_W-1] | u_q[1][U_W-1] | u_q[2][U_W-1];
    s_d   = SUM_W'(u_q[0]) + SUM_W'(u_q[1]) + SUM_W'(u_q[2]);
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          d_q[i][j] <= {vert_i[i][j][COORD_WIDTH-1], vert_i[i][j]}
                     - {start_i[j][COORD_WIDTH-1], start_i[j]};
        end
      end
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          m_q[k][j][0] <= d_q[X_VTX[k]][NXT1[j]] * d_q[Y_VTX[k]][NXT2[j]];
          m_q[k][j][1] <= d_q[X_VTX[k]][NXT2[j]] * d_q[Y_VTX[k]][NXT1[j]];
          cr_q[k][j]   <= {m_q[k][j][0][PROD_W-1], m_q[k][j][0]}
                        - {m_q[k][j][1][PROD_W-1], m_q[k][j][1]};
          hi_q[k][j]   <= $signed(cr_q[k][j][CROSS_W-1:LO_W]) * pq_i[j];
          lo_q[k][j]   <= $signed({1'b0, cr_q[k][j][LO_W-1:0]}) * pq_i[j];
        end
        u_q[k] <= u_d[k];
        x_q[k] <= {1'b0, u_q[k]};
      end
      s_q <= s_d;
    end
  end

  assign flags_o = flags_q;
  assign x_o     = x_q;
  assign s_o     = s_q;

endmodule

@@ sv/rth_wdiv.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, three lanes sharing s.
// Each lane gives floor(x * 2^F / s) for x <= s.
module rth_wdiv import rth_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  rth_flags_t       flags_i,
  input  logic [SUM_W-1:0] x_i [3],
  input  logic [SUM_W-1:0] s_i,
  output rth_flags_t       flags_o,
  output weight_t          wgt_o [3]
);

  rth_flags_t       f_q  [DIV_STG];
  logic [SUM_W-1:0] s_q  [DIV_STG];
  logic [REM_W-1:0] r_q  [DIV_STG][3];
  weight_t          q_q  [DIV_STG][3];
  logic [REM_W-1:0] r_d  [DIV_STG][3];
  weight_t          q_d  [DIV_STG][3];
  logic [REM_W-1:0] r_in [DIV_STG][3];
  weight_t          q_in [DIV_STG][3];
  logic [REM_W-1:0] t_d  [DIV_STG];
  logic             ge   [DIV_STG][3];

  // Trial subtract of s << b at every stage
  always_comb begin
    for (int i = 0; i < DIV_STG; i++) begin
      if (i == 0) begin
        t_d[i] = REM_W'(s_i) << (WEIGHT_FRAC_BITS - i);
      end else begin
        t_d[i] = REM_W'(s_q[i-1]) << (WEIGHT_FRAC_BITS - i);
      end
      for (int k = 0; k < 3; k++) begin
        if (i == 0) begin
          r_in[i][k] = REM_W'(x_i[k]) << WEIGHT_FRAC_BITS;
          q_in[i][k] = '0;
        end else begin
          r_in[i][k] = r_q[i-1][k];
          q_in[i][k] = q_q[i-1][k];
        end
        ge[i][k]  = (r_in[i][k] >= t_d[i]);
        r_d[i][k] = ge[i][k] ? (r_in[i][k] - t_d[i]) : r_in[i][k];
        q_d[i][k] = q_in[i][k] | (WGT_W'(ge[i][k]) << (WEIGHT_FRAC_BITS - i));
      end
    end
  end

  // Flags ride with the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_STG; i++) f_q[i] <= '0;
    end else if (en_i) begin
      f_q[0] <= flags_i;
      for (int i = 1; i < DIV_STG; i++) f_q[i] <= f_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0] <= s_i;
      for (int i = 1; i < DIV_STG; i++) s_q[i] <= s_q[i-1];
      for (int i = 0; i < DIV_STG; i++) begin
        for (int k = 0; k < 3; k++) begin
          r_q[i][k] <= r_d[i][k];
          q_q[i][k] <= q_d[i][k];
        end
      end
    end
  end

  assign flags_o = f_q[DIV_STG-1];
  for (genvar k = 0; k < 3; k++) begin : g_out
    assign wgt_o[k] = q_q[DIV_STG-1][k];
  end

endmodule

@@ sv/ray_triangle_hit_test.sv @@
// Stages: 6 geometry stages, 17 divider stages, one output register.
// Throughput: one triangle per cycle; the whole pipeline holds while a result
// beat waits at the output, so tri_i.ready follows the output register.
// Reset clears all ray registers to zero and empties the pipeline.
`timescale 1ns / 1ps
`include "ray_triangle_hit_test_defines.svh"

module ray_triangle_hit_test import rth_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rth_tri_if.sink               tri_i,
  rth_res_if.source             res_o
);

  logic             en;
  coord_t           start [3];
  diff_t            pq    [3];
  coord_t           vert  [3][3];
  rth_flags_t       g_flags;
  rth_flags_t       d_flags;
  logic [SUM_W-1:0] gx [3];
  logic [SUM_W-1:0] gs;
  weight_t          wgt [3];
  logic             out_valid_q;
  logic             hit_q, deg_q;
  weight_t          wa_q, wb_q, wc_q;
  logic [WGT_W+1:0] wsum;

  // Pipeline advances unless a result beat is stuck at the output
  assign en          = !out_valid_q || res_o.ready;
  assign tri_i.ready = en;

  assign vert[0][0] = tri_i.a_x;
  assign vert[0][1] = tri_i.a_y;
  assign vert[0][2] = tri_i.a_z;
  assign vert[1][0] = tri_i.b_x;
  assign vert[1][1] = tri_i.b_y;
  assign vert[1][2] = tri_i.b_z;
  assign vert[2][0] = tri_i.c_x;
  assign vert[2][1] = tri_i.c_y;
  assign vert[2][2] = tri_i.c_z;

  rth_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start_o    (start),
    .pq_o       (pq)
  );

  rth_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tri_i.valid),
    .vert_i  (vert),
    .start_i (start),
    .pq_i    (pq),
    .flags_o (g_flags),
    .x_o     (gx),
    .s_o     (gs)
  );

  rth_wdiv u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .flags_i (g_flags),
    .x_i     (gx),
    .s_i     (gs),
    .flags_o (d_flags),
    .wgt_o   (wgt)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_flags.valid;
    end
  end

  // Weights are forced to zero on a miss or a degenerate triangle
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= d_flags.hit;
      deg_q <= d_flags.degenerate;
      wa_q  <= d_flags.hit ? wgt[0] : '0;
      wb_q  <= d_flags.hit ? wgt[1] : '0;
      wc_q  <= d_flags.hit ? wgt[2] : '0;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.hit        = hit_q;
  assign res_o.degenerate = deg_q;
  assign res_o.weight_a   = wa_q;
  assign res_o.weight_b   = wb_q;
  assign res_o.weight_c   = wc_q;

  assign wsum = (WGT_W+2)'(wa_q) + (WGT_W+2)'(wb_q) + (WGT_W+2)'(wc_q);

  `RTH_ASSERT_IMP(a_hit_deg_excl, out_valid_q, !(hit_q && deg_q), "hit and degenerate both set")
  `RTH_ASSERT_IMP(a_miss_zero, out_valid_q && !hit_q, (wsum == '0), "non-zero weight on a miss")
  `RTH_ASSERT_IMP(a_hit_sum, out_valid_q && hit_q, (wsum <= (WGT_W+2)'(1 << WEIGHT_FRAC_BITS)) && (wsum + (WGT_W+2)'(2) >= (WGT_W+2)'(1 << WEIGHT_FRAC_BITS)), "weights do not sum to one")
  `RTH_ASSERT_NXT(a_stall_hold, out_valid_q && !res_o.ready, out_valid_q && $stable(wsum), "result lost while stalled")

endmodule
